### hw/rtl/tmpag_pkg.sv
// shared constants and types for the tiled matrix pack address generator
// no dependencies; imported by tiled_matrix_pack_address_gen

package tmpag_pkg;

    // configuration register fields
    localparam int CFG_DIM_W   = 13;
    localparam int CFG_LVL_W   = 2;
    localparam int CFG_MODE_W  = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = CFG_DIM_W;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATRIX_ROWS     = 3'd0,
        REG_MATRIX_COLS     = 3'd1,
        REG_TILE_ROWS_OUTER = 3'd2,
        REG_TILE_COLS_OUTER = 3'd3,
        REG_TILE_ROWS_INNER = 3'd4,
        REG_TILE_COLS_INNER = 3'd5,
        REG_LEVELS_IN_USE   = 3'd6,
        REG_MODE_BITS       = 3'd7
    } t_cfg_reg;

    // mode register bits
    localparam int MODE_UNPACK_BIT = 3;
    localparam int MODE_COL_LEVELS = 3;

    // reset values of the registers
    localparam logic [CFG_DIM_W-1:0]  RST_MATRIX_DIM = CFG_DIM_W'(1);
    localparam logic [CFG_DIM_W-1:0]  RST_TILE_DIM   = '0;
    localparam logic [CFG_LVL_W-1:0]  RST_LEVELS     = CFG_LVL_W'(1);
    localparam logic [CFG_MODE_W-1:0] RST_MODE       = '0;

    // stream payloads
    localparam int OFS_W       = 24;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_FIELD_W = 2 * OFS_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // parameter defaults
    localparam int DEF_MAX_LEVELS = 3;
    localparam int DEF_MAX_DIM    = 4096;

endpackage

### hw/rtl/tiled_matrix_pack_address_gen.sv
// address generator for copying a column-major matrix to or from a tiled packed layout
// depends on tmpag_pkg

// usage
//   configuration: write registers through i_cfg_we / i_cfg_index / i_cfg_data while idle;
//   the values are latched by the next start item and stay fixed for that walk
//   input stream (s_axis): one item per tick while tready is high; tdata bit 0 = start_req.
//   a start item restarts the walk and yields no result; every other item during an
//   active walk yields one (matrix offset, packed offset) pair in packed order,
//   and a non-start item with no walk active yields nothing
//   output stream (m_axis): tdata = matrix_offset, packed_offset; tuser = to_matrix;
//   tlast marks the final pair of the walk
//   path: an accepted item passes the walk state stage, then the row + col * rows
//   multiply into the output register
//   throughput: one item per cycle unless stalled; the per-level position counters
//   advance combinationally, so the multiplier stage is the only other step in the path
//   stall: when the output register is held the walk stage still takes one more
//   item; with both stages full tready drops until the receiver takes the pair
//   reset: synchronous active low; registers return to rows 1, cols 1, tiles 0,
//   one level, pack direction; no walk active, pipeline empty

module tiled_matrix_pack_address_gen #(
    parameter int MAX_LEVELS = tmpag_pkg::DEF_MAX_LEVELS,
    parameter int MAX_DIM    = tmpag_pkg::DEF_MAX_DIM
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [tmpag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tmpag_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [tmpag_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // [0] start_req, rest zero
    // output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [tmpag_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,  // [23:0] matrix_offset,
                                                               // [47:24] packed_offset
    output logic                              o_m_axis_tuser,  // [0] to_matrix
    output logic                              o_m_axis_tlast   // last pair of the walk
);

    import tmpag_pkg::*;

    // internal dimension width follows the largest size the walk must hold
    localparam int DIM_NEED = $clog2(MAX_DIM + 1);
    localparam int DIM_W    = (DIM_NEED < CFG_DIM_W) ? DIM_NEED : CFG_DIM_W;
    localparam int LVL_W    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PROD_W   = 2 * DIM_W + 1;

    // clamp a register size to the largest supported dimension
    function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (int'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    // configuration registers
    logic [CFG_DIM_W-1:0]  r_cfg_rows;
    logic [CFG_DIM_W-1:0]  r_cfg_cols;
    logic [CFG_DIM_W-1:0]  r_cfg_tr_outer;
    logic [CFG_DIM_W-1:0]  r_cfg_tc_outer;
    logic [CFG_DIM_W-1:0]  r_cfg_tr_inner;
    logic [CFG_DIM_W-1:0]  r_cfg_tc_inner;
    logic [CFG_LVL_W-1:0]  r_cfg_levels;
    logic [CFG_MODE_W-1:0] r_cfg_mode;

    // walk state, latched at start
    logic [DIM_W-1:0]      r_lat_rows;
    logic [DIM_W-1:0]      r_lat_cols;
    logic [LVL_W-1:0]      r_lat_leaf;
    logic [CFG_MODE_W-1:0] r_lat_mode;
    logic [DIM_W-1:0]      r_lat_tile_r [MAX_LEVELS];
    logic [DIM_W-1:0]      r_lat_tile_c [MAX_LEVELS];
    logic [DIM_W-1:0]      r_pos_r      [MAX_LEVELS];
    logic [DIM_W-1:0]      r_pos_c      [MAX_LEVELS];
    logic [OFS_W-1:0]      r_packed_cnt;
    logic                  r_walk_active;

    // walk stage output (row, col of the pair, multiplied next)
    logic                  r_s1_valid;
    logic [DIM_W-1:0]      r_s1_row;
    logic [DIM_W-1:0]      r_s1_col;
    logic [DIM_W-1:0]      r_s1_rows;
    logic [OFS_W-1:0]      r_s1_packed;
    logic                  r_s1_unpack;
    logic                  r_s1_last;

    // output register
    logic                  r_out_valid;
    logic [OFS_W-1:0]      r_out_matrix;
    logic [OFS_W-1:0]      r_out_packed;
    logic                  r_out_unpack;
    logic                  r_out_last;

    // handshake
    logic                  s1_move;
    logic                  in_acc;
    logic                  start_acc;
    logic                  step_acc;

    // per-level geometry and next positions
    logic [DIM_W-1:0]      ext_r   [MAX_LEVELS];
    logic [DIM_W-1:0]      ext_c   [MAX_LEVELS];
    logic [DIM_W-1:0]      til_r   [MAX_LEVELS];
    logic [DIM_W-1:0]      til_c   [MAX_LEVELS];
    logic [DIM_W-1:0]      n_pos_r [MAX_LEVELS];
    logic [DIM_W-1:0]      n_pos_c [MAX_LEVELS];
    logic [DIM_W-1:0]      cur_row;
    logic [DIM_W-1:0]      cur_col;
    logic                  step_done;

    // start-time values
    logic [2:0]            lvl_clamp;
    logic [PROD_W-1:0]     mo_full;

    // the walk stage frees whenever the output register can take its pair
    assign s1_move         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_move;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign start_acc       = in_acc && i_s_axis_tdata[0];
    assign step_acc        = in_acc && !i_s_axis_tdata[0] && r_walk_active;

    // level count: zero reads as one, clipped to the built depth
    always_comb begin
        lvl_clamp = (r_cfg_levels == '0) ? 3'd1 : 3'(r_cfg_levels);
        if (int'(lvl_clamp) > MAX_LEVELS) begin
            lvl_clamp = 3'(MAX_LEVELS);
        end
    end

    // block extents and tile sizes of each level from the current positions
    always_comb begin
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (l == 0) begin
                ext_r[l] = r_lat_rows;
                ext_c[l] = r_lat_cols;
            end else begin
                // child block is the parent tile, clipped at the parent's edge
                ext_r[l] = (r_pos_r[l-1] < ext_r[l-1]) ?
                           ((til_r[l-1] < ext_r[l-1] - r_pos_r[l-1]) ?
                            til_r[l-1] : ext_r[l-1] - r_pos_r[l-1]) : '0;
                ext_c[l] = (r_pos_c[l-1] < ext_c[l-1]) ?
                           ((til_c[l-1] < ext_c[l-1] - r_pos_c[l-1]) ?
                            til_c[l-1] : ext_c[l-1] - r_pos_c[l-1]) : '0;
            end
            // tile size zero means the whole block
            til_r[l] = (r_lat_tile_r[l] != '0) ? r_lat_tile_r[l] : ext_r[l];
            til_c[l] = (r_lat_tile_c[l] != '0) ? r_lat_tile_c[l] : ext_c[l];
        end
    end

    // element coordinate: sum of the offsets of all levels down to the leaf
    always_comb begin
        cur_row = '0;
        cur_col = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (l <= int'(r_lat_leaf)) begin
                cur_row = cur_row + r_pos_r[l];
                cur_col = cur_col + r_pos_c[l];
            end
        end
    end

    // odometer advance: leaf steps by one element, outer levels by one tile,
    // a level moves only when every level below it wrapped
    always_comb begin
        logic             carry;
        logic             col_major;
        logic [DIM_W:0]   stp_r;
        logic [DIM_W:0]   stp_c;
        logic [DIM_W:0]   sum_r;
        logic [DIM_W:0]   sum_c;
        carry     = 1'b1;
        col_major = 1'b0;
        stp_r     = '0;
        stp_c     = '0;
        sum_r     = '0;
        sum_c     = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            n_pos_r[l] = r_pos_r[l];
            n_pos_c[l] = r_pos_c[l];
        end
        for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
            if (l <= int'(r_lat_leaf) && carry) begin
                col_major = (l < MODE_COL_LEVELS) ? r_lat_mode[l] : 1'b0;
                if (l == int'(r_lat_leaf)) begin
                    stp_r = (DIM_W+1)'(1);
                    stp_c = (DIM_W+1)'(1);
                end else begin
                    stp_r = {1'b0, til_r[l]};
                    stp_c = {1'b0, til_c[l]};
                end
                sum_r = {1'b0, r_pos_r[l]} + stp_r;
                sum_c = {1'b0, r_pos_c[l]} + stp_c;
                if (col_major) begin
                    if (sum_r < {1'b0, ext_r[l]}) begin
                        n_pos_r[l] = DIM_W'(sum_r);
                        carry      = 1'b0;
                    end else begin
                        n_pos_r[l] = '0;
                        if (sum_c < {1'b0, ext_c[l]}) begin
                            n_pos_c[l] = DIM_W'(sum_c);
                            carry      = 1'b0;
                        end else begin
                            n_pos_c[l] = '0;
                        end
                    end
                end else begin
                    if (sum_c < {1'b0, ext_c[l]}) begin
                        n_pos_c[l] = DIM_W'(sum_c);
                        carry      = 1'b0;
                    end else begin
                        n_pos_c[l] = '0;
                        if (sum_r < {1'b0, ext_r[l]}) begin
                            n_pos_r[l] = DIM_W'(sum_r);
                            carry      = 1'b0;
                        end else begin
                            n_pos_r[l] = '0;
                        end
                    end
                end
            end
        end
        step_done = carry;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows     <= RST_MATRIX_DIM;
            r_cfg_cols     <= RST_MATRIX_DIM;
            r_cfg_tr_outer <= RST_TILE_DIM;
            r_cfg_tc_outer <= RST_TILE_DIM;
            r_cfg_tr_inner <= RST_TILE_DIM;
            r_cfg_tc_inner <= RST_TILE_DIM;
            r_cfg_levels   <= RST_LEVELS;
            r_cfg_mode     <= RST_MODE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_MATRIX_ROWS:     r_cfg_rows     <= i_cfg_data;
                REG_MATRIX_COLS:     r_cfg_cols     <= i_cfg_data;
                REG_TILE_ROWS_OUTER: r_cfg_tr_outer <= i_cfg_data;
                REG_TILE_COLS_OUTER: r_cfg_tc_outer <= i_cfg_data;
                REG_TILE_ROWS_INNER: r_cfg_tr_inner <= i_cfg_data;
                REG_TILE_COLS_INNER: r_cfg_tc_inner <= i_cfg_data;
                REG_LEVELS_IN_USE:   r_cfg_levels   <= CFG_LVL_W'(i_cfg_data);
                REG_MODE_BITS:       r_cfg_mode     <= CFG_MODE_W'(i_cfg_data);
                default:             r_cfg_mode     <= r_cfg_mode;
            endcase
        end
    end

    // latched walk setup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_rows <= '0;
            r_lat_cols <= '0;
            r_lat_leaf <= '0;
            r_lat_mode <= '0;
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_lat_tile_r[l] <= '0;
                r_lat_tile_c[l] <= '0;
            end
        end else if (start_acc) begin
            r_lat_rows <= sat_dim(r_cfg_rows);
            r_lat_cols <= sat_dim(r_cfg_cols);
            r_lat_leaf <= LVL_W'(lvl_clamp - 3'd1);
            r_lat_mode <= r_cfg_mode;
            for (int l = 0; l < MAX_LEVELS; l++) begin
                // only the outer and inner levels have programmable tiles
                if (l == 0) begin
                    r_lat_tile_r[l] <= sat_dim(r_cfg_tr_outer);
                    r_lat_tile_c[l] <= sat_dim(r_cfg_tc_outer);
                end else if (l == 1) begin
                    r_lat_tile_r[l] <= sat_dim(r_cfg_tr_inner);
                    r_lat_tile_c[l] <= sat_dim(r_cfg_tc_inner);
                end else begin
                    r_lat_tile_r[l] <= '0;
                    r_lat_tile_c[l] <= '0;
                end
            end
        end
    end

    // positions, packed counter and walk flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_pos_r[l] <= '0;
                r_pos_c[l] <= '0;
            end
            r_packed_cnt  <= '0;
            r_walk_active <= 1'b0;
        end else if (start_acc) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_pos_r[l] <= '0;
                r_pos_c[l] <= '0;
            end
            r_packed_cnt  <= '0;
            // empty matrix gives an empty walk
            r_walk_active <= (r_cfg_rows != '0) && (r_cfg_cols != '0);
        end else if (step_acc) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_pos_r[l] <= n_pos_r[l];
                r_pos_c[l] <= n_pos_c[l];
            end
            r_packed_cnt <= r_packed_cnt + OFS_W'(1);
            if (step_done) begin
                r_walk_active <= 1'b0;
            end
        end
    end

    // walk stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (step_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_acc) begin
            r_s1_row    <= cur_row;
            r_s1_col    <= cur_col;
            r_s1_rows   <= r_lat_rows;
            r_s1_packed <= r_packed_cnt;
            r_s1_unpack <= r_lat_mode[MODE_UNPACK_BIT];
            r_s1_last   <= step_done;
        end
    end

    // column-major element index, wraps at the offset width
    assign mo_full = PROD_W'(r_s1_col) * PROD_W'(r_s1_rows) + PROD_W'(r_s1_row);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_valid) begin
            r_out_matrix <= OFS_W'(mo_full);
            r_out_packed <= r_s1_packed;
            r_out_unpack <= r_s1_unpack;
            r_out_last   <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_packed, r_out_matrix});
    assign o_m_axis_tuser  = r_out_unpack;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // final step of a walk clears the walk flag
    a_done_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_acc && step_done |=> !r_walk_active)
        else $error("walk still active after its last pair");

    // outer level position stays inside the matrix during a walk
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk_active |-> (r_pos_r[0] < r_lat_rows) && (r_pos_c[0] < r_lat_cols))
        else $error("outer position outside matrix");

    // a held walk stage keeps its pair
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && $stable(r_s1_packed))
        else $error("walk stage pair lost while stalled");

    // start restarts the packed count
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_acc |=> r_packed_cnt == '0)
        else $error("packed counter not cleared by start");
`endif

endmodule

### dv/tb_top.sv
// self-checking bench for tiled_matrix_pack_address_gen: drives start and step items,
// predicts every address pair in a scoreboard class and checks the output stream
// depends on tmpag_pkg and the tiled_matrix_pack_address_gen rtl
`timescale 1ns / 1ps

module tb_top;
    import tmpag_pkg::*;

    localparam int ITEM_GOAL      = 1850;
    localparam int PIPE_DRAIN     = 4;     // two-stage pipe plus margin
    localparam int WATCHDOG_LIMIT = 2000;

    // one expected address pair
    typedef struct packed {
        logic [OFS_W-1:0] mofs;
        logic [OFS_W-1:0] pofs;
        logic             to_matrix;
        logic             last;
    } t_addr_pair;

    // tracks the register file, the latched walk and the pairs still owed by the block
    class t_pack_walk_scoreboard;
        bit [CFG_DATA_W-1:0] cfg_shadow [8];
        int unsigned         walk_rows, walk_cols, walk_levels;
        bit [CFG_MODE_W-1:0] walk_mode;
        int unsigned         walk_tile_r [3], walk_tile_c [3];
        int unsigned         row_pos [3], col_pos [3];
        bit [OFS_W-1:0]      pair_count;
        bit                  walking;
        t_addr_pair          pending_pairs [$];
        int                  errors;

        function new();
            foreach (cfg_shadow[i]) cfg_shadow[i] = RST_TILE_DIM;
            cfg_shadow[REG_MATRIX_ROWS]   = RST_MATRIX_DIM;
            cfg_shadow[REG_MATRIX_COLS]   = RST_MATRIX_DIM;
            cfg_shadow[REG_LEVELS_IN_USE] = CFG_DATA_W'(RST_LEVELS);
            cfg_shadow[REG_MODE_BITS]     = CFG_DATA_W'(RST_MODE);
            walk_levels = 1;
        endfunction

        function int unsigned sat_dim(bit [CFG_DIM_W-1:0] v);
            return (v > DEF_MAX_DIM) ? DEF_MAX_DIM : v;
        endfunction

        function void write_reg(t_cfg_reg idx, bit [CFG_DATA_W-1:0] val);
            case (idx)
                REG_LEVELS_IN_USE: cfg_shadow[idx] = CFG_DATA_W'(val[CFG_LVL_W-1:0]);
                REG_MODE_BITS:     cfg_shadow[idx] = CFG_DATA_W'(val[CFG_MODE_W-1:0]);
                default:           cfg_shadow[idx] = val;
            endcase
        endfunction

        // advances the walk by one accepted item; returns 1 for a start or a produced pair
        function bit walk_step(bit start_bit);
            int unsigned dr [3], dc [3], orr [3], orc [3], tr [3], tc [3];
            int unsigned l, leaf, row, col, step_r, step_c;
            bit          wrapped;
            t_addr_pair  exp_pair;
            if (start_bit) begin
                walk_rows = sat_dim(cfg_shadow[REG_MATRIX_ROWS]);
                walk_cols = sat_dim(cfg_shadow[REG_MATRIX_COLS]);
                walk_levels = cfg_shadow[REG_LEVELS_IN_USE];
                if (walk_levels < 1) walk_levels = 1;
                if (walk_levels > DEF_MAX_LEVELS) walk_levels = DEF_MAX_LEVELS;
                walk_mode = cfg_shadow[REG_MODE_BITS][CFG_MODE_W-1:0];
                walk_tile_r[0] = sat_dim(cfg_shadow[REG_TILE_ROWS_OUTER]);
                walk_tile_c[0] = sat_dim(cfg_shadow[REG_TILE_COLS_OUTER]);
                walk_tile_r[1] = sat_dim(cfg_shadow[REG_TILE_ROWS_INNER]);
                walk_tile_c[1] = sat_dim(cfg_shadow[REG_TILE_COLS_INNER]);
                walk_tile_r[2] = 0;
                walk_tile_c[2] = 0;
                row_pos = '{0, 0, 0};
                col_pos = '{0, 0, 0};
                pair_count = '0;
                walking = (walk_rows != 0) && (walk_cols != 0);
                return 1'b1;
            end
            if (!walking) return 1'b0;

            // block extent, origin and tile size per level
            dr[0] = walk_rows;
            dc[0] = walk_cols;
            orr[0] = 0;
            orc[0] = 0;
            for (l = 0; l < walk_levels; l++) begin
                tr[l] = (walk_tile_r[l] != 0) ? walk_tile_r[l] : dr[l];
                tc[l] = (walk_tile_c[l] != 0) ? walk_tile_c[l] : dc[l];
                if (l + 1 < walk_levels) begin
                    dr[l+1] = (row_pos[l] >= dr[l]) ? 0 :
                              (tr[l] < dr[l] - row_pos[l]) ? tr[l] : dr[l] - row_pos[l];
                    dc[l+1] = (col_pos[l] >= dc[l]) ? 0 :
                              (tc[l] < dc[l] - col_pos[l]) ? tc[l] : dc[l] - col_pos[l];
                    orr[l+1] = orr[l] + row_pos[l];
                    orc[l+1] = orc[l] + col_pos[l];
                end
            end
            leaf = walk_levels - 1;
            row = orr[leaf] + row_pos[leaf];
            col = orc[leaf] + col_pos[leaf];
            exp_pair.mofs = OFS_W'(row + col * walk_rows);
            exp_pair.pofs = pair_count;
            exp_pair.to_matrix = walk_mode[MODE_UNPACK_BIT];

            // carry from the leaf outward while levels wrap
            wrapped = 1'b1;
            l = walk_levels;
            while (wrapped && l > 0) begin
                l--;
                step_r = (l == leaf) ? 1 : tr[l];
                step_c = (l == leaf) ? 1 : tc[l];
                if (walk_mode[l]) begin
                    row_pos[l] += step_r;
                    if (row_pos[l] < dr[l]) begin
                        wrapped = 1'b0;
                    end else begin
                        row_pos[l] = 0;
                        col_pos[l] += step_c;
                        if (col_pos[l] < dc[l]) wrapped = 1'b0;
                        else col_pos[l] = 0;
                    end
                end else begin
                    col_pos[l] += step_c;
                    if (col_pos[l] < dc[l]) begin
                        wrapped = 1'b0;
                    end else begin
                        col_pos[l] = 0;
                        row_pos[l] += step_r;
                        if (row_pos[l] < dr[l]) wrapped = 1'b0;
                        else row_pos[l] = 0;
                    end
                end
            end
            pair_count++;
            if (wrapped) walking = 1'b0;
            exp_pair.last = wrapped;
            pending_pairs.push_back(exp_pair);
            return 1'b1;
        endfunction

        function void check_pair(logic [OUT_DATA_W-1:0] data, logic user, logic last);
            t_addr_pair exp_pair;
            if (pending_pairs.size() == 0) begin
                $error("unexpected pair: matrix_offset %0d packed_offset %0d",
                       data[OFS_W-1:0], data[2*OFS_W-1:OFS_W]);
                errors++;
                return;
            end
            exp_pair = pending_pairs.pop_front();
            if (data[OFS_W-1:0] !== exp_pair.mofs) begin
                $error("matrix_offset: expected %0d, got %0d", exp_pair.mofs, data[OFS_W-1:0]);
                errors++;
            end
            if (data[2*OFS_W-1:OFS_W] !== exp_pair.pofs) begin
                $error("packed_offset: expected %0d, got %0d", exp_pair.pofs,
                       data[2*OFS_W-1:OFS_W]);
                errors++;
            end
            if (user !== exp_pair.to_matrix) begin
                $error("to_matrix: expected %0d, got %0d", exp_pair.to_matrix, user);
                errors++;
            end
            if (last !== exp_pair.last) begin
                $error("last: expected %0d, got %0d", exp_pair.last, last);
                errors++;
            end
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;

    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    t_pack_walk_scoreboard sb;
    bit [CFG_DATA_W-1:0]   next_cfg [8];   // values for the next register programming
    int                    items_done = 0; // starts and pair-producing steps accepted
    int                    src_idle_pct = 28;
    int                    snk_stall_pct = 47;
    int                    quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tiled_matrix_pack_address_gen dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [0] start_req
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [23:0] matrix_offset, [47:24] packed_offset
        .o_m_axis_tuser  (m_tuser),   // [0] to_matrix
        .o_m_axis_tlast  (m_tlast)
    );

    // offers one item, with a random gap first; returns at the edge where it is taken
    // and leaves tvalid high so back-to-back items need no second assignment
    task automatic send_item(input bit start_bit);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_DATA_W-1){1'b0}}, start_bit};
        do @(posedge clk); while (!s_tready);
        if (sb.walk_step(start_bit)) items_done++;
    endtask

    // stops sending, waits for every owed pair, then lets the pipe drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_pairs.size() != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // writes the selected registers from next_cfg, one per cycle
    task automatic program_regs(input bit [7:0] sel);
        for (int i = 0; i < 8; i++) begin
            if (sel[i]) begin
                cfg_we <= 1'b1;
                cfg_index <= t_cfg_reg'(i);
                cfg_data <= next_cfg[i];
                @(posedge clk);
                sb.write_reg(t_cfg_reg'(i), next_cfg[i]);
            end
        end
        cfg_we <= 1'b0;
    endtask

    // matrix size: mostly small, sometimes zero or anything up to the field limit
    function automatic bit [CFG_DATA_W-1:0] pick_dim();
        int r;
        r = $urandom_range(63);
        if (r == 0) return '0;
        if (r < 4) return CFG_DATA_W'($urandom_range(8191));
        return CFG_DATA_W'($urandom_range(1, 9));
    endfunction

    // tile size: whole block, a small tile, or anything up to the field limit
    function automatic bit [CFG_DATA_W-1:0] pick_tile();
        int r;
        r = $urandom_range(15);
        if (r == 0) return CFG_DATA_W'($urandom_range(8191));
        if (r < 5) return '0;
        return CFG_DATA_W'($urandom_range(1, 6));
    endfunction

    // receiver: check every taken pair, then stall at random
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_pair(m_tdata, m_tuser, m_tlast);
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog on cycles where neither stream moves an item
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[tiled_matrix_pack_address_gen] ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned pairs, steps;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick before any walk, then the 1x1 walk of the reset values
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);

        // zero rows: empty walk
        settle();
        next_cfg = '{0, 3, 0, 0, 0, 0, 1, 0};
        program_regs(8'hFF);
        send_item(1'b1);
        send_item(1'b0);

        // 3x2 in two levels, outer 2-row tiles row-major, leaf column-major, unpack
        settle();
        next_cfg = '{3, 2, 2, 0, 0, 0, 2, (1 << MODE_UNPACK_BIT) | 2};
        program_regs(8'hFF);
        send_item(1'b1);
        repeat (6) send_item(1'b0);

        // sizes and outer tiles at their top values and saturate, inner tiles at the largest dimension, three levels
        settle();
        next_cfg = '{8191, 8191, 8191, 8191, 4096, 4096, 3, 15};
        program_regs(8'hFF);
        send_item(1'b1);
        repeat (3) send_item(1'b0);

        // zero level count, and a rows write mid-walk that waits for the next start
        settle();
        next_cfg = '{2, 1, 0, 0, 0, 0, 0, 0};
        program_regs(8'hFF);
        send_item(1'b1);
        send_item(1'b0);
        settle();
        next_cfg[REG_MATRIX_ROWS] = 7;
        program_regs(8'h01);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);

        // random phases: receiver stalls most, then sender idles most, then both at full rate
        while (items_done < ITEM_GOAL) begin
            if (items_done < ITEM_GOAL / 3) begin
                src_idle_pct = 28;
                snk_stall_pct = 47;
            end else if (items_done < 2 * ITEM_GOAL / 3) begin
                src_idle_pct = 47;
                snk_stall_pct = 28;
            end else begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            settle();
            next_cfg[REG_MATRIX_ROWS] = pick_dim();
            next_cfg[REG_MATRIX_COLS] = pick_dim();
            next_cfg[REG_TILE_ROWS_OUTER] = pick_tile();
            next_cfg[REG_TILE_COLS_OUTER] = pick_tile();
            next_cfg[REG_TILE_ROWS_INNER] = pick_tile();
            next_cfg[REG_TILE_COLS_INNER] = pick_tile();
            next_cfg[REG_LEVELS_IN_USE] = CFG_DATA_W'($urandom_range(3));
            next_cfg[REG_MODE_BITS] = CFG_DATA_W'($urandom_range(15));
            program_regs(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));

            if ($urandom_range(9) == 0) begin
                // noise: restarts and steps in random order
                repeat ($urandom_range(5, 30)) send_item($urandom_range(3) == 0);
            end else begin
                send_item(1'b1);
                pairs = sb.walk_rows * sb.walk_cols;
                if (pairs == 0) begin
                    steps = $urandom_range(1, 2);
                end else if (pairs > 300 || $urandom_range(4) == 0) begin
                    // cut-off walk, the next phase restarts it
                    steps = $urandom_range(1, (pairs > 40) ? 40 : pairs);
                end else begin
                    // full walk plus a few idle ticks past its end
                    steps = pairs + $urandom_range(0, 2);
                end
                repeat (steps) send_item(1'b0);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending_pairs.size() == 0) begin
            $display("[tiled_matrix_pack_address_gen] OK");
        end else begin
            $display("[tiled_matrix_pack_address_gen] ERROR");
        end
        $finish;
    end

endmodule
